// File: src/entry_table_heap_allocator_assert.svh
// Assertion macros for the heap allocator checker.
// Used by entry_table_heap_allocator_chk.sv; no other dependencies.
`ifndef ENTRY_TABLE_HEAP_ALLOCATOR_ASSERT_SVH
`define ENTRY_TABLE_HEAP_ALLOCATOR_ASSERT_SVH
`define ETHA_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ETHA_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: src/etha_pkg.sv
// Package for the heap allocator: status codes, operation codes, widths.
// No dependencies.
package etha_pkg;
    localparam int ADDR_W = 32;
    localparam int SLOT_OUT_W = 6;
    localparam logic [4:0] ALIGN_MASK = 5'h1F;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_NO_ENTRY  = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

// File: src/entry_table_heap_allocator.sv
// Heap allocator over a fixed slot table, top level.
// Depends on etha_pkg.
//
// channel   | handshake                 | payload
// in        | in_valid / in_stall       | operation, request_size, block_address
// out       | out_valid / out_stall     | status, result_address, slot_used
// cfg       | cfg_we                    | cfg_wdata (heap_base)
//
// Table held in a memory read one entry a cycle by a shared compare unit.
// Alloc: free-slot scan of all entries, then for each used entry u a read, a neighbor
// scan of all entries and two tests; unused entries are skipped.
// Free: a scan of the entries for the block address.
// Reset clears valid flip-flops at once; no clearing pass.
// out stall only delays the result; next input is taken once the result leaves.
module entry_table_heap_allocator #(
    parameter int TABLE_SLOTS = 64,
    parameter int HEAP_BYTES  = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] request_size,
    input  logic [31:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] result_address,
    output logic [5:0]  slot_used
);
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int OW = $clog2(HEAP_BYTES);
    localparam int SW = OW + 1;
    localparam int XW = SW + 2;
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_FSCAN, S_UREAD, S_UWAIT, S_NSCAN, S_NX, S_PV, S_TEST1, S_TEST2,
        S_FREE, S_DONE
    } state_t;

    state_t state_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [OW-1:0] off_mem [TABLE_SLOTS];
    logic [SW-1:0] size_mem [TABLE_SLOTS];
    logic [31:0] base_reg;
    logic [31:0] req_reg, addr_reg;
    logic [SW-1:0] sz_reg;
    logic [IW-1:0] fresh_reg, u_reg, ri_reg;
    logic [CW-1:0] cnt_reg;
    logic fresh_ok_reg, any_reg;
    logic [OW-1:0] rd_off_reg, uo_reg, nxo_reg, pvo_reg;
    logic [SW-1:0] rd_size_reg, us_reg, pvs_reg;
    logic nx_ok_reg, pv_ok_reg, rd_v_reg;
    logic [2:0] status_reg;
    logic [31:0] res_reg;
    logic [5:0] slot_reg;
    logic wr_en;
    logic [IW-1:0] wr_idx;
    logic [OW-1:0] wr_off;
    logic [SW-1:0] wr_size;

    logic [IW-1:0] rd_idx;
    logic [IW-1:0] ci;
    logic last;
    logic [XW-1:0] end_u, end_pv, sz_x;

    assign ci = cnt_reg[IW-1:0];
    assign last = (cnt_reg == CW'(TABLE_SLOTS - 1));
    assign rd_idx = (state_reg == S_UREAD) ? u_reg : ci;
    assign sz_x = XW'(sz_reg);
    assign end_u = XW'(uo_reg) + XW'(us_reg) + sz_x;
    assign end_pv = XW'(pvo_reg) + XW'(pvs_reg) + sz_x;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status = status_reg;
    assign result_address = res_reg;
    assign slot_used = slot_reg;

    always_ff @(posedge clk)
    begin
        rd_off_reg <= off_mem[rd_idx];
        rd_size_reg <= size_mem[rd_idx];
        if (wr_en)
        begin
            off_mem[wr_idx] <= wr_off;
            size_mem[wr_idx] <= wr_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            base_reg <= 32'd1;
            wr_en <= 1'b0;
        end
        else
        begin
            rd_v_reg <= valid_reg[rd_idx];
            if (cfg_we)
                base_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= request_size;
                        addr_reg <= block_address;
                        cnt_reg <= '0;
                        fresh_ok_reg <= 1'b0;
                        any_reg <= 1'b0;
                        state_reg <= (operation == etha_pkg::OP_FREE) ? S_FREE : S_FSCAN;
                    end
                end
                S_FREE:
                begin
                    // scan entries in turn, address check from current memory
                    res_reg <= '0;
                    slot_reg <= '0;
                    if (addr_reg == 32'd0)
                    begin
                        status_reg <= etha_pkg::ST_DONE;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        status_reg <= etha_pkg::ST_NOT_FOUND;
                        state_reg <= S_NSCAN;
                    end
                    u_reg <= '0;
                    cnt_reg <= '0;
                end
                S_FSCAN:
                begin
                    if (req_reg == 32'd0 || req_reg > 32'(HEAP_BYTES))
                    begin
                        status_reg <= etha_pkg::ST_BAD_SIZE;
                        res_reg <= '0;
                        slot_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sz_reg <= SW'((33'(req_reg) + 33'(etha_pkg::ALIGN_MASK))
                            & ~33'(etha_pkg::ALIGN_MASK));
                        if (!valid_reg[ci] && !fresh_ok_reg)
                        begin
                            fresh_ok_reg <= 1'b1;
                            fresh_reg <= ci;
                        end
                        if (valid_reg[ci])
                            any_reg <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (last)
                        begin
                            u_reg <= '0;
                            if (!fresh_ok_reg && valid_reg[ci])
                            begin
                                status_reg <= etha_pkg::ST_NO_ENTRY;
                                res_reg <= '0;
                                slot_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            else if (!any_reg && !valid_reg[ci])
                            begin
                                wr_en <= 1'b1;
                                wr_idx <= fresh_reg;
                                wr_off <= '0;
                                wr_size <= sz_reg;
                                valid_reg[fresh_reg] <= 1'b1;
                                status_reg <= etha_pkg::ST_DONE;
                                res_reg <= base_reg;
                                slot_reg <= 6'(fresh_reg);
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_UREAD;
                        end
                    end
                end
                S_UREAD:
                begin
                    if (!valid_reg[u_reg])
                    begin
                        if (u_reg == IW'(TABLE_SLOTS - 1))
                        begin
                            status_reg <= etha_pkg::ST_NO_SPACE;
                            res_reg <= '0;
                            slot_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                            u_reg <= u_reg + 1'b1;
                    end
                    else
                        state_reg <= S_UWAIT;
                end
                S_UWAIT:
                begin
                    uo_reg <= rd_off_reg;
                    us_reg <= rd_size_reg;
                    nx_ok_reg <= 1'b0;
                    pv_ok_reg <= 1'b0;
                    cnt_reg <= '0;
                    state_reg <= S_NX;
                end
                S_NX:
                begin
                    // issue read of entry 0; data arrives next cycle
                    ri_reg <= ci;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= S_PV;
                end
                S_PV:
                begin
                    // compare entry ri (data now registered), issue next read
                    if (rd_v_reg && ri_reg != u_reg)
                    begin
                        if (rd_off_reg > uo_reg && (!nx_ok_reg || rd_off_reg < nxo_reg))
                        begin
                            nx_ok_reg <= 1'b1;
                            nxo_reg <= rd_off_reg;
                        end
                        if (rd_off_reg < uo_reg && (!pv_ok_reg || rd_off_reg > pvo_reg))
                        begin
                            pv_ok_reg <= 1'b1;
                            pvo_reg <= rd_off_reg;
                            pvs_reg <= rd_size_reg;
                        end
                    end
                    ri_reg <= ci;
                    if (ri_reg == IW'(TABLE_SLOTS - 1))
                        state_reg <= S_TEST1;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_TEST1:
                begin
                    if (nx_ok_reg ? (end_u < XW'(nxo_reg)) : (end_u <= HEAP_X))
                    begin
                        wr_en <= 1'b1;
                        wr_idx <= fresh_reg;
                        wr_off <= OW'(XW'(uo_reg) + XW'(us_reg));
                        wr_size <= sz_reg;
                        valid_reg[fresh_reg] <= 1'b1;
                        status_reg <= etha_pkg::ST_DONE;
                        res_reg <= base_reg + 32'(XW'(uo_reg) + XW'(us_reg));
                        slot_reg <= 6'(fresh_reg);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_TEST2;
                end
                S_TEST2:
                begin
                    if (pv_ok_reg ? (end_pv < XW'(uo_reg)) : (XW'(uo_reg) >= sz_x))
                    begin
                        wr_en <= 1'b1;
                        wr_idx <= fresh_reg;
                        wr_size <= sz_reg;
                        valid_reg[fresh_reg] <= 1'b1;
                        status_reg <= etha_pkg::ST_DONE;
                        slot_reg <= 6'(fresh_reg);
                        state_reg <= S_DONE;
                        if (pv_ok_reg)
                        begin
                            wr_off <= OW'(XW'(pvo_reg) + XW'(pvs_reg));
                            res_reg <= base_reg + 32'(XW'(pvo_reg) + XW'(pvs_reg));
                        end
                        else
                        begin
                            wr_off <= OW'(XW'(uo_reg) - sz_x);
                            res_reg <= base_reg + 32'(XW'(uo_reg) - sz_x);
                        end
                    end
                    else if (u_reg == IW'(TABLE_SLOTS - 1))
                    begin
                        status_reg <= etha_pkg::ST_NO_SPACE;
                        res_reg <= '0;
                        slot_reg <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        u_reg <= u_reg + 1'b1;
                        state_reg <= S_UREAD;
                    end
                end
                S_NSCAN:
                begin
                    // free search: cnt_reg gives the issued index, data arrives in the next cycle under ri_reg
                    if (cnt_reg != '0 && rd_v_reg
                        && base_reg + 32'(rd_off_reg) == addr_reg)
                    begin
                        valid_reg[ri_reg] <= 1'b0;
                        wr_en <= 1'b1;
                        wr_idx <= ri_reg;
                        wr_off <= '0;
                        wr_size <= '0;
                        status_reg <= etha_pkg::ST_DONE;
                        slot_reg <= 6'(ri_reg);
                        state_reg <= S_DONE;
                    end
                    else if (cnt_reg != '0 && ri_reg == IW'(TABLE_SLOTS - 1))
                        state_reg <= S_DONE;
                    else
                    begin
                        ri_reg <= ci;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    // table write issued on entry lands while here, then wr_en is cleared
                    wr_en <= 1'b0;
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/entry_table_heap_allocator_chk.sv
// Port-level checker for the heap allocator, with its bind.
// Depends on entry_table_heap_allocator_assert.svh and etha_pkg.
`include "entry_table_heap_allocator_assert.svh"
module entry_table_heap_allocator_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] result_address,
    input logic [5:0]  slot_used
);
    `ETHA_ASSERT_IMPL(a_busy, out_valid, in_stall)
    `ETHA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_address))
    `ETHA_ASSERT_IMPL(a_fail_zero, out_valid && status != etha_pkg::ST_DONE,
        result_address == 32'd0 && slot_used == 6'd0)
    `ETHA_ASSERT_IMPL(a_code, out_valid, status <= etha_pkg::ST_NOT_FOUND)
    `ETHA_ASSERT_NEXT(a_take, in_valid && !in_stall, in_stall)
endmodule

bind entry_table_heap_allocator entry_table_heap_allocator_chk u_chk (.*);

// File: tb/entry_table_heap_allocator_tb.sv
// Testbench for entry_table_heap_allocator: directed and random alloc/free traffic
// with a slot-table predictor and a result scoreboard. Depends on etha_pkg.
`timescale 1ns / 1ps

class alloc_scoreboard;
    typedef struct {
        etha_pkg::status_t st;
        logic [31:0]       addr;
        logic [5:0]        slot;
    } outcome_t;

    logic [31:0] base;
    bit          used [64];
    logic [15:0] off [64];
    logic [16:0] len [64];
    outcome_t    expected [$];
    int          errors;

    function void clear();
        base = 32'd1;
        for (int i = 0; i < 64; i++)
        begin
            used[i] = 0;
            off[i] = '0;
            len[i] = '0;
        end
        expected.delete();
        errors = 0;
    endfunction

    function outcome_t make(etha_pkg::status_t st, logic [31:0] a, logic [5:0] s);
        outcome_t r;
        r.st = st;
        r.addr = a;
        r.slot = s;
        return r;
    endfunction

    function outcome_t claim(int s, int unsigned o, int unsigned n);
        used[s] = 1;
        off[s] = o[15:0];
        len[s] = n[16:0];
        return make(etha_pkg::ST_DONE, base + 32'(o), 6'(s));
    endfunction

    function outcome_t alloc(logic [31:0] req);
        int unsigned n, uo, us, o;
        int fresh, nx, pv;
        bit any;
        fresh = -1;
        any = 0;
        if (req == 0 || req > 32'd65536)
            return make(etha_pkg::ST_BAD_SIZE, 0, 0);
        n = (req + 31) & ~32'd31;
        for (int i = 63; i >= 0; i--)
        begin
            if (!used[i])
                fresh = i;
            else
                any = 1;
        end
        if (fresh < 0)
            return make(etha_pkg::ST_NO_ENTRY, 0, 0);
        if (!any)
            return claim(fresh, 0, n);
        for (int u = 0; u < 64; u++)
        begin
            if (!used[u])
                continue;
            uo = off[u];
            us = len[u];
            nx = -1;
            pv = -1;
            for (int i = 0; i < 64; i++)
            begin
                if (!used[i] || i == u)
                    continue;
                o = off[i];
                if (o > uo && (nx < 0 || o < off[nx]))
                    nx = i;
                if (o < uo && (pv < 0 || o > off[pv]))
                    pv = i;
            end
            if (nx < 0)
            begin
                if (uo + us + n <= 65536)
                    return claim(fresh, uo + us, n);
            end
            else if (uo + us + n < off[nx])
                return claim(fresh, uo + us, n);
            if (pv < 0)
            begin
                if (uo >= n)
                    return claim(fresh, uo - n, n);
            end
            else if (off[pv] + len[pv] + n < uo)
                return claim(fresh, off[pv] + len[pv], n);
        end
        return make(etha_pkg::ST_NO_SPACE, 0, 0);
    endfunction

    function outcome_t release_block(logic [31:0] a);
        if (a == 0)
            return make(etha_pkg::ST_DONE, 0, 0);
        for (int i = 0; i < 64; i++)
        begin
            if (used[i] && base + 32'(off[i]) == a)
            begin
                used[i] = 0;
                off[i] = '0;
                len[i] = '0;
                return make(etha_pkg::ST_DONE, 0, 6'(i));
            end
        end
        return make(etha_pkg::ST_NOT_FOUND, 0, 0);
    endfunction

    function void note_transfer(logic op, logic [31:0] req, logic [31:0] a);
        if (op == etha_pkg::OP_ALLOC)
            expected.push_back(alloc(req));
        else
            expected.push_back(release_block(a));
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] a, logic [5:0] s);
        outcome_t e;
        if (expected.size() == 0)
        begin
            $error("unexpected result: status %0d addr %h slot %0d", st, a, s);
            errors++;
            return;
        end
        e = expected.pop_front();
        if (st !== e.st)
        begin
            $error("status: expected %0d, got %0d", e.st, st);
            errors++;
        end
        if (a !== e.addr)
        begin
            $error("result_address: expected %h, got %h", e.addr, a);
            errors++;
        end
        if (s !== e.slot)
        begin
            $error("slot_used: expected %0d, got %0d", e.slot, s);
            errors++;
        end
    endfunction

    // address of a random live block, 0 if the table is empty
    function logic [31:0] live_address();
        int picks [$];
        for (int i = 0; i < 64; i++)
            if (used[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return 0;
        return base + 32'(off[picks[$urandom_range(picks.size() - 1)]]);
    endfunction
endclass

module entry_table_heap_allocator_tb;
    localparam int IDLE_LIMIT = 40000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        operation = etha_pkg::OP_ALLOC;
    logic [31:0] request_size = '0;
    logic [31:0] block_address = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [31:0] result_address;
    logic [5:0]  slot_used;

    alloc_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;

    entry_table_heap_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .request_size(request_size),
        .block_address(block_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .result_address(result_address),
        .slot_used(slot_used)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_transfer(operation, request_size, block_address);
            if (out_valid && !out_stall)
                sb.check_result(status, result_address, slot_used);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern: switches between no stall, light and heavy stalling
    always @(negedge clk)
    begin
        if ($urandom_range(63) == 0)
            stall_mode = $urandom_range(2);
        case (stall_mode)
            0: out_stall = 0;
            1: out_stall = ($urandom_range(3) == 0);
            default: out_stall = ($urandom_range(7) != 0);
        endcase
    end

    task automatic send(logic op, logic [31:0] req, logic [31:0] a);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            repeat ($urandom_range(1) ? $urandom_range(6) : 0)
            begin
                @(negedge clk);
                in_valid = 0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1;
        operation = op;
        request_size = req;
        block_address = a;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] v);
        drain();
        repeat (10) @(negedge clk);
        cfg_we = 1;
        cfg_wdata = v;
        @(posedge clk);
        sb.base = v;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic random_item();
        int r;
        logic [31:0] a;
        r = $urandom_range(99);
        if (r < 45)
            send(etha_pkg::OP_ALLOC, $urandom_range(2048, 1), $urandom);
        else if (r < 52)
            send(etha_pkg::OP_ALLOC, $urandom_range(65536, 4096), $urandom);
        else if (r < 56)
            send(etha_pkg::OP_ALLOC, $urandom, $urandom);
        else if (r < 88)
        begin
            a = sb.live_address();
            send(etha_pkg::OP_FREE, $urandom, a);
        end
        else if (r < 92)
            send(etha_pkg::OP_FREE, $urandom, 0);
        else
            send(etha_pkg::OP_FREE, $urandom, $urandom);
    endtask

    initial
    begin
        logic [31:0] bases [5];
        bases = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_8000, 32'h0};
        bases[4] = $urandom_range(32'hFFFF_FFFF, 1);
        sb.clear();
        repeat (7) @(negedge clk);
        rst_n = 1;

        write_base(32'h0001_0000);
        send(etha_pkg::OP_ALLOC, 0, 0);
        send(etha_pkg::OP_ALLOC, 32'd65537, 0);
        send(etha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(etha_pkg::OP_ALLOC, 1, 0);
        send(etha_pkg::OP_ALLOC, 32, 0);
        send(etha_pkg::OP_ALLOC, 33, 0);
        send(etha_pkg::OP_ALLOC, 65536, 0);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0020);
        send(etha_pkg::OP_ALLOC, 64, 0);
        send(etha_pkg::OP_FREE, 32'hFFFF_FFFF, 0);
        send(etha_pkg::OP_FREE, 0, 32'h1234_5678);
        send(etha_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0000);
        send(etha_pkg::OP_ALLOC, 31, 0);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0040);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0000);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0060);
        send(etha_pkg::OP_ALLOC, 65536, 0);
        send(etha_pkg::OP_ALLOC, 1, 0);
        send(etha_pkg::OP_FREE, 0, 32'h0001_0000);

        // heap base near the top so placed blocks wrap past zero
        write_base(32'hFFFF_FFE0);
        send(etha_pkg::OP_ALLOC, 32, 0);
        send(etha_pkg::OP_ALLOC, 32, 0);
        send(etha_pkg::OP_FREE, 0, 32'hFFFF_FFE0);
        send(etha_pkg::OP_FREE, 0, 32'h0000_0000);

        for (int p = 0; p < 5; p++)
        begin
            write_base(bases[p]);
            if (p == 2)
            begin
                // fill the table to run out of entries, then thin it out
                for (int k = 0; k < 66; k++)
                    send(etha_pkg::OP_ALLOC, $urandom_range(96, 1), 0);
                repeat (8) send(etha_pkg::OP_FREE, 0, sb.live_address());
            end
            else
                repeat (12) random_item();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
